/* hdl/mesh_volume_gradient_accumulator_defines.svh */
// Assertion macros shared by the mesh volume gradient accumulator RTL
`ifndef MESH_VOLUME_GRADIENT_ACCUMULATOR_DEFINES_SVH
`define MESH_VOLUME_GRADIENT_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MVGA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("mvga assertion failed");

// Next-cycle implication, disabled during reset
`define MVGA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("mvga assertion failed");

`endif

/* hdl/mvga_pkg.sv */
// Package: shared constants, types and helpers of the gradient accumulator
`timescale 1ns / 1ps
`default_nettype none

package mvga_pkg;

  localparam int NUM_VERTS_DEF = 1024;
  localparam int IDX_W         = 10;
  localparam int COORD_W       = 24;
  localparam int PROD_W        = 2 * COORD_W;
  localparam int DIFF_W        = PROD_W + 1;
  localparam int ACC_W         = 60;

  // Command codes
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_FACE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Gradient divisor
  localparam logic [3:0] DIV_CONST = 4'd6;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } pos_vec_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] z;
  } acc_vec_t;

  // Divider status and quotients
  typedef struct packed {
    logic     done;
    acc_vec_t quo;
  } div_res_t;

  // Saturating add of a cross-product term into an accumulator
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                 input logic [DIFF_W-1:0] d);
    logic [ACC_W:0] s;
    s = {acc[ACC_W-1], acc} + {{(ACC_W + 1 - DIFF_W){d[DIFF_W-1]}}, d};
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* hdl/mvga_if.sv */
// Interfaces: request channel and result channel
`timescale 1ns / 1ps
`default_nettype none

interface mvga_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [1:0]                              cmd;
  logic [mvga_pkg::IDX_W-1:0]              index_a;
  logic [mvga_pkg::IDX_W-1:0]              index_b;
  logic [mvga_pkg::IDX_W-1:0]              index_c;
  logic signed [mvga_pkg::COORD_W-1:0]     coord_x;
  logic signed [mvga_pkg::COORD_W-1:0]     coord_y;
  logic signed [mvga_pkg::COORD_W-1:0]     coord_z;

  modport source (output valid, cmd, index_a, index_b, index_c, coord_x, coord_y, coord_z,
                  input ready);
  modport sink (input valid, cmd, index_a, index_b, index_c, coord_x, coord_y, coord_z,
                output ready);
endinterface

interface mvga_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [mvga_pkg::IDX_W-1:0]            vertex_index;
  logic signed [mvga_pkg::ACC_W-1:0]     grad_x;
  logic signed [mvga_pkg::ACC_W-1:0]     grad_y;
  logic signed [mvga_pkg::ACC_W-1:0]     grad_z;

  modport source (output valid, vertex_index, grad_x, grad_y, grad_z, input ready);
  modport sink (input valid, vertex_index, grad_x, grad_y, grad_z, output ready);
endinterface

`default_nettype wire

/* hdl/mvga_ram.sv */
// Single-port synchronous RAM, registered read data
`timescale 1ns / 1ps
`default_nettype none

module mvga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   addr,
  input  wire logic [WIDTH-1:0]           wdata,
  output      logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and read-old in one port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hdl/mvga_div6.sv */
// Signed divide by six, three lanes, six quotient bits per cycle, truncating toward zero
`timescale 1ns / 1ps
`default_nettype none

module mvga_div6 (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire mvga_pkg::acc_vec_t dividend,
  output      mvga_pkg::div_res_t res
);

  localparam int W     = mvga_pkg::ACC_W;
  localparam int STEP  = 6;
  localparam int NSTEP = W / STEP;
  localparam int CW    = $clog2(NSTEP);

  logic [W-1:0]  mag_r [3];
  logic [W-1:0]  mag_nxt [3];
  logic [2:0]    rem_r [3];
  logic [2:0]    rem_nxt [3];
  logic [2:0]    neg_r;
  logic [W-1:0]  src [3];
  logic [W-1:0]  quo [3];
  logic [3:0]    t [3];
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  assign src[0] = dividend.x;
  assign src[1] = dividend.y;
  assign src[2] = dividend.z;

  // STEP restoring steps per lane and cycle: shift in next bit, subtract six if it fits
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem_nxt[l] = rem_r[l];
      mag_nxt[l] = mag_r[l];
      t[l]       = '0;
      for (int j = 0; j < STEP; j++) begin
        t[l]       = {rem_nxt[l], mag_nxt[l][W-1]};
        mag_nxt[l] = {mag_nxt[l][W-2:0], 1'b0};
        if (t[l] >= mvga_pkg::DIV_CONST) begin
          rem_nxt[l]    = 3'(t[l] - mvga_pkg::DIV_CONST);
          mag_nxt[l][0] = 1'b1;
        end else begin
          rem_nxt[l] = t[l][2:0];
        end
      end
      quo[l] = neg_r[l] ? (W'(0) - mag_r[l]) : mag_r[l];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(NSTEP - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Lane datapath: load magnitudes, then iterate
  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      if (start) begin
        neg_r[l] <= src[l][W-1];
        mag_r[l] <= src[l][W-1] ? (W'(0) - src[l]) : src[l];
        rem_r[l] <= '0;
      end else if (busy_r) begin
        mag_r[l] <= mag_nxt[l];
        rem_r[l] <= rem_nxt[l];
      end
    end
  end

  assign res.done  = done_r;
  assign res.quo.x = quo[0];
  assign res.quo.y = quo[1];
  assign res.quo.z = quo[2];

endmodule

`default_nettype wire

/* hdl/mesh_volume_gradient_accumulator.sv */
// Top level: mesh volume gradient accumulator
//
//  channel   | dir | payload                                       | handshake
//  in_chan   | in  | cmd, index_a/b/c, coord_x/y/z                 | valid/ready
//  out_chan  | out | vertex_index, grad_x/y/z                      | valid/ready
//
// A face makes three position reads from the one position RAM port and three
// read-modify-write passes on the accumulator RAM. A read runs the ten-step
// divide by six (six quotient bits a step); a read of an index out of range
// skips the divide. After reset a clearing pass zeroes the accumulator RAM,
// during which no request is taken. A full result register lets the block
// take new requests; a read waits at its end until that register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "mesh_volume_gradient_accumulator_defines.svh"

module mesh_volume_gradient_accumulator #(
  parameter int NUM_VERTS = mvga_pkg::NUM_VERTS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  mvga_in_if.sink       in_chan,
  mvga_out_if.source    out_chan
);

  localparam int AW     = $clog2(NUM_VERTS);
  localparam int PW     = $bits(mvga_pkg::pos_vec_t);
  localparam int ACCW   = $bits(mvga_pkg::acc_vec_t);
  localparam int DW     = mvga_pkg::DIFF_W;
  localparam int CRW    = mvga_pkg::COORD_W;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_F_RDA = 4'd2;
  localparam logic [3:0] ST_F_RDB = 4'd3;
  localparam logic [3:0] ST_F_RDC = 4'd4;
  localparam logic [3:0] ST_F_CPC = 4'd5;
  localparam logic [3:0] ST_F_MUL = 4'd6;
  localparam logic [3:0] ST_F_SUB = 4'd7;
  localparam logic [3:0] ST_F_WR  = 4'd8;
  localparam logic [3:0] ST_R_RD  = 4'd9;
  localparam logic [3:0] ST_R_DIV = 4'd10;
  localparam logic [3:0] ST_R_WT  = 4'd11;
  localparam logic [3:0] ST_R_OUT = 4'd12;

  logic [3:0]  state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [1:0]  k_r;
  logic        out_valid_r;

  logic [AW-1:0] ia_r, ib_r, ic_r, tgt;
  logic [mvga_pkg::IDX_W-1:0] vidx_r;
  logic        zero_r;
  mvga_pkg::pos_vec_t pa_r, pb_r, pc_r, u, v, pos_rd, pos_wdata;
  logic signed [mvga_pkg::PROD_W-1:0] prod_r [6];
  logic [DW-1:0] dx_r, dy_r, dz_r;

  logic [mvga_pkg::IDX_W-1:0] o_idx_r;
  logic [mvga_pkg::ACC_W-1:0] o_gx_r, o_gy_r, o_gz_r;

  logic        in_acc, ia_ok, ib_ok, ic_ok;
  logic        pos_we, acc_we, div_start, out_load;
  logic [AW-1:0] pos_addr, acc_addr;
  mvga_pkg::acc_vec_t acc_rd, acc_wdata;
  mvga_pkg::div_res_t div_res;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc = in_chan.valid && in_chan.ready;
  assign ia_ok  = (32'(in_chan.index_a) < NUM_VERTS);
  assign ib_ok  = (32'(in_chan.index_b) < NUM_VERTS);
  assign ic_ok  = (32'(in_chan.index_c) < NUM_VERTS);

  assign pos_wdata.x = in_chan.coord_x;
  assign pos_wdata.y = in_chan.coord_y;
  assign pos_wdata.z = in_chan.coord_z;

  // Cross-product operands and target for the current pass
  always_comb begin
    case (k_r)
      2'd0: begin
        u = pb_r; v = pc_r; tgt = ia_r;
      end
      2'd1: begin
        u = pc_r; v = pa_r; tgt = ib_r;
      end
      default: begin
        u = pa_r; v = pb_r; tgt = ic_r;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    pos_we    = 1'b0;
    pos_addr  = AW'(in_chan.index_a);
    acc_we    = 1'b0;
    acc_addr  = clr_cnt_r;
    acc_wdata = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        acc_we = 1'b1;
        if (clr_cnt_r == AW'(NUM_VERTS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_chan.cmd)
            mvga_pkg::CMD_LOAD: pos_we = ia_ok;
            mvga_pkg::CMD_FACE: if (ia_ok && ib_ok && ic_ok) state_nxt = ST_F_RDA;
            mvga_pkg::CMD_READ: state_nxt = ia_ok ? ST_R_RD : ST_R_OUT;
            default: ;
          endcase
        end
      end
      ST_F_RDA: begin
        pos_addr = ia_r; state_nxt = ST_F_RDB;
      end
      ST_F_RDB: begin
        pos_addr = ib_r; state_nxt = ST_F_RDC;
      end
      ST_F_RDC: begin
        pos_addr = ic_r; state_nxt = ST_F_CPC;
      end
      ST_F_CPC: state_nxt = ST_F_MUL;
      ST_F_MUL: state_nxt = ST_F_SUB;
      ST_F_SUB: begin
        acc_addr  = tgt;
        state_nxt = ST_F_WR;
      end
      ST_F_WR: begin
        acc_addr    = tgt;
        acc_we      = 1'b1;
        acc_wdata.x = mvga_pkg::sat_add(acc_rd.x, dx_r);
        acc_wdata.y = mvga_pkg::sat_add(acc_rd.y, dy_r);
        acc_wdata.z = mvga_pkg::sat_add(acc_rd.z, dz_r);
        state_nxt   = (k_r == 2'd2) ? ST_IDLE : ST_F_MUL;
      end
      ST_R_RD: begin
        acc_addr  = ia_r;
        state_nxt = ST_R_DIV;
      end
      ST_R_DIV: begin
        // start the divide and clear the entry
        acc_addr  = ia_r;
        acc_we    = 1'b1;
        div_start = 1'b1;
        state_nxt = ST_R_WT;
      end
      ST_R_WT: if (div_res.done) state_nxt = ST_R_OUT;
      ST_R_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (state_r == ST_IDLE) k_r <= '0;
      else if (state_r == ST_F_WR) k_r <= k_r + 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      ia_r   <= AW'(in_chan.index_a);
      ib_r   <= AW'(in_chan.index_b);
      ic_r   <= AW'(in_chan.index_c);
      vidx_r <= in_chan.index_a;
      zero_r <= !ia_ok;
    end
    if (state_r == ST_F_RDB) pa_r <= pos_rd;
    if (state_r == ST_F_RDC) pb_r <= pos_rd;
    if (state_r == ST_F_CPC) pc_r <= pos_rd;
    // six partial products of one cross product
    if (state_r == ST_F_MUL) begin
      prod_r[0] <= u.y * v.z;
      prod_r[1] <= u.z * v.y;
      prod_r[2] <= u.z * v.x;
      prod_r[3] <= u.x * v.z;
      prod_r[4] <= u.x * v.y;
      prod_r[5] <= u.y * v.x;
    end
    if (state_r == ST_F_SUB) begin
      dx_r <= {prod_r[0][2*CRW-1], prod_r[0]} - {prod_r[1][2*CRW-1], prod_r[1]};
      dy_r <= {prod_r[2][2*CRW-1], prod_r[2]} - {prod_r[3][2*CRW-1], prod_r[3]};
      dz_r <= {prod_r[4][2*CRW-1], prod_r[4]} - {prod_r[5][2*CRW-1], prod_r[5]};
    end
    // result register
    if (out_load) begin
      o_idx_r <= vidx_r;
      o_gx_r  <= zero_r ? '0 : div_res.quo.x;
      o_gy_r  <= zero_r ? '0 : div_res.quo.y;
      o_gz_r  <= zero_r ? '0 : div_res.quo.z;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.vertex_index = o_idx_r;
  assign out_chan.grad_x       = o_gx_r;
  assign out_chan.grad_y       = o_gy_r;
  assign out_chan.grad_z       = o_gz_r;

  mvga_ram #(.WIDTH(PW), .DEPTH(NUM_VERTS)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .addr  (pos_addr),
    .wdata (pos_wdata),
    .rdata (pos_rd)
  );

  mvga_ram #(.WIDTH(ACCW), .DEPTH(NUM_VERTS)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .addr  (acc_addr),
    .wdata (acc_wdata),
    .rdata (acc_rd)
  );

  mvga_div6 u_div6 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_rd),
    .res      (div_res)
  );

  // Checks
  `MVGA_ASSERT_IMP(a_acc_we_state, clk, rst_n, acc_we, (state_r == ST_CLEAR || state_r == ST_F_WR || state_r == ST_R_DIV))
  `MVGA_ASSERT_NXT(a_clear_sweep, clk, rst_n, (state_r == ST_CLEAR && clr_cnt_r != AW'(NUM_VERTS - 1)), (state_r == ST_CLEAR && clr_cnt_r == AW'($past(clr_cnt_r) + 1'b1)))
  `MVGA_ASSERT_IMP(a_out_slot_free, clk, rst_n, out_load, (!out_valid_r || out_chan.ready))

endmodule

`default_nettype wire

/* bench/tb.sv */
// Testbench for the mesh volume gradient accumulator: directed table, large sums, random traffic
`timescale 1ns / 1ps

module tb;

  localparam int         IDX_W      = mvga_pkg::IDX_W;
  localparam int         ACC_W      = mvga_pkg::ACC_W;
  localparam int         COORD_W    = mvga_pkg::COORD_W;
  localparam int         NV         = mvga_pkg::NUM_VERTS_DEF;
  localparam logic [1:0] CMD_SPARE  = 2'd3;
  localparam longint     GRAD_MAX   = (64'sd1 <<< 59) - 1;
  localparam longint     GRAD_MIN   = -(64'sd1 <<< 59);
  localparam int         CYCLE_LIMIT = 2000000;
  localparam int         BIG_FACES  = 24;
  localparam int         RAND_ITEMS = 360;

  typedef struct {
    logic [1:0]          cmd;
    logic [IDX_W-1:0]    ia;
    logic [IDX_W-1:0]    ib;
    logic [IDX_W-1:0]    ic;
    mvga_pkg::pos_vec_t  pos;
    bit                  typed;    // expected gradient written in the row
    logic [ACC_W-1:0]    gx;
    logic [ACC_W-1:0]    gy;
    logic [ACC_W-1:0]    gz;
  } request_t;

  typedef struct {
    logic [IDX_W-1:0] vidx;
    logic [ACC_W-1:0] gx;
    logic [ACC_W-1:0] gy;
    logic [ACC_W-1:0] gz;
  } gradient_t;

  logic clk;
  logic rst_n;
  mvga_in_if  in_if ();
  mvga_out_if out_if ();

  mesh_volume_gradient_accumulator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Mirror of the block's stores
  mvga_pkg::pos_vec_t vert_pos [NV];
  longint             grad_acc [NV][3];
  logic [IDX_W-1:0]   loaded_q [$];
  bit                 is_loaded [NV];
  gradient_t          pending_grads [$];

  int errors;
  int checked;
  int send_gap_pct;
  int recv_stall_pct;
  int hold_seq;
  int cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles,
                 pending_grads.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [ACC_W-1:0] got,
                                 input logic [ACC_W-1:0] want);
    errors++;
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  function automatic longint sat_sum(input longint acc, input longint d);
    longint s;
    s = acc + d;
    if (s > GRAD_MAX) s = GRAD_MAX;
    if (s < GRAD_MIN) s = GRAD_MIN;
    return s;
  endfunction

  // u x v with Q3.20 operands, Q.40 result
  function automatic void cross_prod(input mvga_pkg::pos_vec_t u, input mvga_pkg::pos_vec_t v,
                                     output longint r [3]);
    r[0] = longint'(u.y) * longint'(v.z) - longint'(u.z) * longint'(v.y);
    r[1] = longint'(u.z) * longint'(v.x) - longint'(u.x) * longint'(v.z);
    r[2] = longint'(u.x) * longint'(v.y) - longint'(u.y) * longint'(v.x);
  endfunction

  function automatic void add_grad(input logic [IDX_W-1:0] v, input longint d [3]);
    for (int k = 0; k < 3; k++) grad_acc[v][k] = sat_sum(grad_acc[v][k], d[k]);
  endfunction

  // Update the mirror for one accepted request; queue the expected gradient
  function automatic void apply_request(input request_t r);
    longint             da [3], db [3], dc [3];
    mvga_pkg::pos_vec_t pa, pb, pc;
    gradient_t          g;
    case (r.cmd)
      mvga_pkg::CMD_LOAD: begin
        vert_pos[r.ia] = r.pos;
        if (!is_loaded[r.ia]) begin
          is_loaded[r.ia] = 1'b1;
          loaded_q.push_back(r.ia);
        end
      end
      mvga_pkg::CMD_FACE: begin
        pa = vert_pos[r.ia];
        pb = vert_pos[r.ib];
        pc = vert_pos[r.ic];
        cross_prod(pb, pc, da);
        cross_prod(pc, pa, db);
        cross_prod(pa, pb, dc);
        add_grad(r.ia, da);
        add_grad(r.ib, db);
        add_grad(r.ic, dc);
      end
      mvga_pkg::CMD_READ: begin
        g.vidx = r.ia;
        g.gx   = ACC_W'(grad_acc[r.ia][0] / 6);
        g.gy   = ACC_W'(grad_acc[r.ia][1] / 6);
        g.gz   = ACC_W'(grad_acc[r.ia][2] / 6);
        if (r.typed) begin
          g.gx = r.gx;
          g.gy = r.gy;
          g.gz = r.gz;
        end
        for (int k = 0; k < 3; k++) grad_acc[r.ia][k] = 0;
        pending_grads.push_back(g);
      end
      default: ;
    endcase
  endfunction

  // Offer one request; valid stays high afterwards unless the next one idles first
  task automatic send_request(input request_t r);
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.cmd     <= r.cmd;
    in_if.index_a <= r.ia;
    in_if.index_b <= r.ib;
    in_if.index_c <= r.ic;
    in_if.coord_x <= r.pos.x;
    in_if.coord_y <= r.pos.y;
    in_if.coord_z <= r.pos.z;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    apply_request(r);
  endtask

  // Result side: check, then pick ready for the next edge
  int hold_seen;
  int hold_left;
  initial begin
    gradient_t g;
    out_if.ready = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        checked++;
        if (pending_grads.size() == 0) begin
          errors++;
          $display("[%0t] unexpected result for vertex %0d", $realtime,
                   out_if.vertex_index);
        end else begin
          g = pending_grads.pop_front();
          if (out_if.vertex_index !== g.vidx)
            report_mismatch("vertex_index", ACC_W'(out_if.vertex_index), ACC_W'(g.vidx));
          if (out_if.grad_x !== g.gx) report_mismatch("grad_x", out_if.grad_x, g.gx);
          if (out_if.grad_y !== g.gy) report_mismatch("grad_y", out_if.grad_y, g.gy);
          if (out_if.grad_z !== g.gz) report_mismatch("grad_z", out_if.grad_z, g.gz);
        end
      end
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(7))
      0: return {1'b1, {(COORD_W-1){1'b0}}};
      1: return {1'b0, {(COORD_W-1){1'b1}}};
      2: return '0;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic request_t make_req(input logic [1:0] cmd, input int ia, input int ib,
                                        input int ic, input int x, input int y, input int z);
    request_t r;
    r.cmd   = cmd;
    r.ia    = IDX_W'(ia);
    r.ib    = IDX_W'(ib);
    r.ic    = IDX_W'(ic);
    r.pos.x = COORD_W'(x);
    r.pos.y = COORD_W'(y);
    r.pos.z = COORD_W'(z);
    r.typed = 1'b0;
    r.gx    = '0;
    r.gy    = '0;
    r.gz    = '0;
    return r;
  endfunction

  function automatic request_t zero_read(input int ia);
    request_t r;
    r       = make_req(mvga_pkg::CMD_READ, ia, 0, 0, 0, 0, 0);
    r.typed = 1'b1;
    return r;
  endfunction

  function automatic request_t random_req();
    request_t r;
    int       pick;
    r    = make_req(mvga_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0);
    pick = $urandom_range(99);
    r.ia = IDX_W'($urandom);
    r.ib = IDX_W'($urandom);
    r.ic = IDX_W'($urandom);
    r.pos.x = pick_coord();
    r.pos.y = pick_coord();
    r.pos.z = pick_coord();
    if (pick < 25) begin
      r.cmd = mvga_pkg::CMD_LOAD;
      if ($urandom_range(3) != 0) r.ia = loaded_q[$urandom_range(loaded_q.size() - 1)];
    end else if (pick < 70) begin
      // faces only name loaded vertices; small pool makes repeats likely
      r.cmd = mvga_pkg::CMD_FACE;
      r.ia  = loaded_q[$urandom_range(loaded_q.size() - 1)];
      r.ib  = loaded_q[$urandom_range(loaded_q.size() - 1)];
      r.ic  = loaded_q[$urandom_range(loaded_q.size() - 1)];
    end else if (pick < 95) begin
      r.cmd = mvga_pkg::CMD_READ;
      if ($urandom_range(3) != 0) r.ia = loaded_q[$urandom_range(loaded_q.size() - 1)];
    end else begin
      r.cmd = CMD_SPARE;
    end
    return r;
  endfunction

  // Stimulus
  request_t dir_table [$];
  initial begin
    int mx, mn;
    request_t r;
    errors         = 0;
    checked        = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_seq       = 0;
    for (int i = 0; i < NV; i++) begin
      is_loaded[i] = 1'b0;
      vert_pos[i]  = '0;
      for (int k = 0; k < 3; k++) grad_acc[i][k] = 0;
    end
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.cmd      <= mvga_pkg::CMD_LOAD;
    in_if.index_a  <= '0;
    in_if.index_b  <= '0;
    in_if.index_c  <= '0;
    in_if.coord_x  <= '0;
    in_if.coord_y  <= '0;
    in_if.coord_z  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    mx = 32'sh7FFFFF;
    mn = -32'sh800000;
    // Directed table: extremes, every command, repeated vertices, clear on read
    dir_table.push_back(zero_read(0));
    dir_table.push_back(zero_read(1023));
    dir_table.push_back(make_req(mvga_pkg::CMD_LOAD, 0, 0, 0, mx, mx, mx));
    dir_table.push_back(make_req(mvga_pkg::CMD_LOAD, 1023, 1023, 1023, mn, mn, mn));
    dir_table.push_back(make_req(mvga_pkg::CMD_LOAD, 1, 0, 0, mx, mn, 0));
    dir_table.push_back(make_req(mvga_pkg::CMD_LOAD, 2, 0, 0, mn, mx, 1));
    dir_table.push_back(make_req(CMD_SPARE, 5, 1023, 1023, mx, mn, mx));
    dir_table.push_back(make_req(mvga_pkg::CMD_FACE, 0, 1, 1023, 0, 0, 0));
    dir_table.push_back(make_req(mvga_pkg::CMD_FACE, 1023, 2, 0, 0, 0, 0));
    dir_table.push_back(make_req(mvga_pkg::CMD_FACE, 0, 0, 1, 0, 0, 0));
    dir_table.push_back(make_req(mvga_pkg::CMD_FACE, 2, 2, 2, 0, 0, 0));
    dir_table.push_back(make_req(mvga_pkg::CMD_READ, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(make_req(mvga_pkg::CMD_READ, 1, 0, 0, 0, 0, 0));
    dir_table.push_back(make_req(mvga_pkg::CMD_READ, 1023, 0, 0, 0, 0, 0));
    dir_table.push_back(make_req(mvga_pkg::CMD_READ, 2, 0, 0, 0, 0, 0));
    dir_table.push_back(zero_read(0));
    dir_table.push_back(make_req(mvga_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0));
    dir_table.push_back(make_req(mvga_pkg::CMD_FACE, 0, 1, 2, 0, 0, 0));
    dir_table.push_back(make_req(mvga_pkg::CMD_FACE, 1, 2, 0, 0, 0, 0));
    dir_table.push_back(make_req(mvga_pkg::CMD_READ, 1, 0, 0, 0, 0, 0));
    dir_table.push_back(make_req(mvga_pkg::CMD_READ, 2, 0, 0, 0, 0, 0));
    foreach (dir_table[i]) send_request(dir_table[i]);

    // Large sums: repeat one face at full-scale coordinates, both orientations
    send_request(make_req(mvga_pkg::CMD_LOAD, 10, 0, 0, 3, mn, 7));
    send_request(make_req(mvga_pkg::CMD_LOAD, 11, 0, 0, mn, mn, 0));
    send_request(make_req(mvga_pkg::CMD_LOAD, 12, 0, 0, mx, mn, 0));
    for (int i = 0; i < BIG_FACES; i++)
      send_request(make_req(mvga_pkg::CMD_FACE, 10, 11, 12, 0, 0, 0));
    for (int v = 10; v <= 12; v++) send_request(make_req(mvga_pkg::CMD_READ, v, 0, 0, 0, 0, 0));
    for (int i = 0; i < BIG_FACES; i++)
      send_request(make_req(mvga_pkg::CMD_FACE, 10, 12, 11, 0, 0, 0));
    for (int v = 10; v <= 12; v++) send_request(make_req(mvga_pkg::CMD_READ, v, 0, 0, 0, 0, 0));

    // Seed a small pool of vertices so faces hit shared entries
    for (int i = 0; i < 12; i++) begin
      r = random_req();
      r.cmd = mvga_pkg::CMD_LOAD;
      r.ia  = IDX_W'($urandom);
      send_request(r);
    end

    // Random traffic through the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 62; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 62; end
        default: begin send_gap_pct = 26; recv_stall_pct = 26; end
      endcase
      if (ph == 2) hold_seq++;   // long receiver hold while requests keep coming
      for (int i = 0; i < RAND_ITEMS / 4; i++) send_request(random_req());
      if (ph == 1) begin
        // drain fully before going on
        in_if.valid <= 1'b0;
        wait (pending_grads.size() == 0);
        @(posedge clk);
      end
    end
    in_if.valid <= 1'b0;

    wait (pending_grads.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered loads, faces with repeated and extreme vertices, large sums of both signs,");
    $display("clear on read and the spare command; %0d gradients checked", checked);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
